// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
// Plain text macros only; each use expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/hbkrd_pkg.sv =====
// Types, constants and the usage-to-keycode table of the boot keyboard report differ.
// No dependencies; imported by the core, lane and merge modules and the testbench.
package hbkrd_pkg;

    typedef logic [7:0] t_key;
    typedef logic [6:0] t_code;

    localparam int INPUT_SLOTS       = 6;
    localparam int ROM_SIZE          = 57;
    localparam int ROM_IDX_W         = 6;
    localparam int MIN_REPORT_LENGTH = 8;
    localparam t_key LAST_NULL_CODE  = 8'd1;

    // Per-word control carried from the front end to the result serializer
    typedef struct packed {
        t_key mods;
        t_key prev_mods;
        logic rejected;
    } t_report_info;

    localparam t_code KEY_ROM [ROM_SIZE] = '{
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h0B, 7'h08, 7'h02,
        7'h0E, 7'h03, 7'h05, 7'h04, 7'h22, 7'h26, 7'h28, 7'h25,
        7'h2E, 7'h2D, 7'h1F, 7'h23, 7'h0C, 7'h0F, 7'h01, 7'h11,
        7'h20, 7'h09, 7'h0D, 7'h07, 7'h10, 7'h06, 7'h12, 7'h13,
        7'h14, 7'h15, 7'h17, 7'h16, 7'h1A, 7'h1C, 7'h19, 7'h1D,
        7'h24, 7'h35, 7'h33, 7'h30, 7'h31, 7'h1B, 7'h18, 7'h21,
        7'h1E, 7'h2A, 7'h29, 7'h27, 7'h32, 7'h2B, 7'h2F, 7'h2C,
        7'h39
    };

    function automatic t_code map_key(input t_key code);
        t_code res;
        res = '0;
        if (code < t_key'(ROM_SIZE)) begin
            res = KEY_ROM[code[ROM_IDX_W-1:0]];
        end
        return res;
    endfunction

endpackage

// ===== design/hid_boot_keyboard_report_differ_core.sv =====
// Boot keyboard report differ: turns each accepted report word into key-down and
// key-up result words by comparing it with the stored previous report. KEY_SLOTS
// compare lanes check all slots at once, and the merge stage registers the word,
// then sends one registered result word per cycle while i_stall is low, so a report
// yielding N results (1 to 2*KEY_SLOTS) holds the input until its last result is
// sent, and an unstalled one-result report flows at one word per cycle. The result
// serializer sets the rate. Writing 1 to the enable clears the stored report.
module hid_boot_keyboard_report_differ_core #(
    parameter int KEY_SLOTS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_modifier_bits,
    input  logic [7:0] i_key_slot_0,
    input  logic [7:0] i_key_slot_1,
    input  logic [7:0] i_key_slot_2,
    input  logic [7:0] i_key_slot_3,
    input  logic [7:0] i_key_slot_4,
    input  logic [7:0] i_key_slot_5,
    input  logic [7:0] i_report_length,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_mapped_keycode,
    output logic [7:0] o_event_modifiers,
    output logic       o_key_pressed,
    output logic       o_has_event,
    output logic       o_rejected,
    output logic       o_last_of_report
);
    import hbkrd_pkg::*;

    logic                 r_enabled;
    t_key                 r_prev_keys [KEY_SLOTS];
    t_key                 r_prev_mods;

    t_key                 in_slots [INPUT_SLOTS];
    t_key                 cur_keys [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] press_raw;
    logic [KEY_SLOTS-1:0] release_raw;
    t_code                press_codes   [KEY_SLOTS];
    t_code                release_codes [KEY_SLOTS];
    t_report_info         info;
    logic                 reject;
    logic                 merge_ready;
    logic                 accept;

    assign in_slots[0] = i_key_slot_0;
    assign in_slots[1] = i_key_slot_1;
    assign in_slots[2] = i_key_slot_2;
    assign in_slots[3] = i_key_slot_3;
    assign in_slots[4] = i_key_slot_4;
    assign in_slots[5] = i_key_slot_5;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        if (g < INPUT_SLOTS) begin : g_in
            assign cur_keys[g] = in_slots[g];
        end else begin : g_pad
            assign cur_keys[g] = '0;
        end

        hbkrd_lane #(
            .KEY_SLOTS (KEY_SLOTS)
        ) u_lane (
            .i_cur_code     (cur_keys[g]),
            .i_prev_code    (r_prev_keys[g]),
            .i_cur_all      (cur_keys),
            .i_prev_all     (r_prev_keys),
            .o_press        (press_raw[g]),
            .o_release      (release_raw[g]),
            .o_press_code   (press_codes[g]),
            .o_release_code (release_codes[g])
        );
    end

    assign reject  = (i_report_length < t_key'(MIN_REPORT_LENGTH)) || !r_enabled;
    assign accept  = i_valid && merge_ready;
    assign o_stall = !merge_ready;

    assign info.mods      = i_modifier_bits;
    assign info.prev_mods = r_prev_mods;
    assign info.rejected  = reject;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    // Advance the stored report on every accepted word that is not rejected, clear it on enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_we && i_cfg_wdata)) begin
            r_prev_mods <= '0;
            for (int j = 0; j < KEY_SLOTS; j++) r_prev_keys[j] <= '0;
        end else if (accept && !reject) begin
            r_prev_mods <= i_modifier_bits;
            for (int j = 0; j < KEY_SLOTS; j++) r_prev_keys[j] <= cur_keys[j];
        end
    end

    hbkrd_merge #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (accept),
        .i_info            (info),
        .i_press_mask      (reject ? '0 : press_raw),
        .i_release_mask    (reject ? '0 : release_raw),
        .i_press_codes     (press_codes),
        .i_release_codes   (release_codes),
        .o_ready           (merge_ready),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_mapped_keycode  (o_mapped_keycode),
        .o_event_modifiers (o_event_modifiers),
        .o_key_pressed     (o_key_pressed),
        .o_has_event       (o_has_event),
        .o_rejected        (o_rejected),
        .o_last_of_report  (o_last_of_report)
    );

endmodule

// ===== design/hbkrd_lane.sv =====
// One compare lane: checks one current slot against all previous slots and
// one previous slot against all current slots. Depends on hbkrd_pkg.
module hbkrd_lane #(
    parameter int KEY_SLOTS = 6
) (
    input  hbkrd_pkg::t_key  i_cur_code,
    input  hbkrd_pkg::t_key  i_prev_code,
    input  hbkrd_pkg::t_key  i_cur_all  [KEY_SLOTS],
    input  hbkrd_pkg::t_key  i_prev_all [KEY_SLOTS],
    output logic             o_press,
    output logic             o_release,
    output hbkrd_pkg::t_code o_press_code,
    output hbkrd_pkg::t_code o_release_code
);
    import hbkrd_pkg::*;

    logic cur_seen_before;
    logic prev_still_held;

    always_comb begin
        cur_seen_before = 1'b0;
        prev_still_held = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (i_prev_all[j] == i_cur_code) cur_seen_before = 1'b1;
            if (i_cur_all[j] == i_prev_code) prev_still_held = 1'b1;
        end
    end

    // Codes 0 and 1 are stored but never raise events
    assign o_press        = (i_cur_code > LAST_NULL_CODE) && !cur_seen_before;
    assign o_release      = (i_prev_code > LAST_NULL_CODE) && !prev_still_held;
    assign o_press_code   = map_key(i_cur_code);
    assign o_release_code = map_key(i_prev_code);

endmodule

// ===== design/hbkrd_merge.sv =====
// Merge stage: holds the lane results of one word and serializes them into
// result words, presses first, then releases. Depends on hbkrd_pkg.
module hbkrd_merge #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  hbkrd_pkg::t_report_info  i_info,
    input  logic [KEY_SLOTS-1:0]     i_press_mask,
    input  logic [KEY_SLOTS-1:0]     i_release_mask,
    input  hbkrd_pkg::t_code         i_press_codes   [KEY_SLOTS],
    input  hbkrd_pkg::t_code         i_release_codes [KEY_SLOTS],
    output logic                     o_ready,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic [6:0]               o_mapped_keycode,
    output logic [7:0]               o_event_modifiers,
    output logic                     o_key_pressed,
    output logic                     o_has_event,
    output logic                     o_rejected,
    output logic                     o_last_of_report
);
    import hbkrd_pkg::*;

    localparam int EVENTS = 2 * KEY_SLOTS;
    localparam int IDX_W  = $clog2(EVENTS);

    logic                r_job_valid;
    logic [EVENTS-1:0]   r_mask;
    t_code               r_codes [EVENTS];
    t_report_info        r_info;

    logic                r_out_valid;
    t_code               r_code;
    t_key                r_mods;
    logic                r_pressed;
    logic                r_event;
    logic                r_rejected;
    logic                r_last;

    logic                emit;
    logic [EVENTS-1:0]   n_mask;
    logic                last;
    logic [IDX_W-1:0]    sel_idx;
    logic                sel_release;
    logic                any_event;

    always_comb begin
        sel_idx = '0;
        for (int j = EVENTS - 1; j >= 0; j--) begin
            if (r_mask[j]) sel_idx = IDX_W'(j);
        end
    end

    assign any_event   = |r_mask;
    assign sel_release = sel_idx >= IDX_W'(KEY_SLOTS);
    // Drop the lowest pending event
    assign n_mask      = r_mask & (r_mask - EVENTS'(1));
    assign last        = !any_event || (n_mask == '0);
    assign emit        = r_job_valid && (!r_out_valid || !i_stall);
    assign o_ready     = !r_job_valid || (emit && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (i_load) begin
            r_job_valid <= 1'b1;
        end else if (emit && last) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mask <= {i_release_mask, i_press_mask};
            r_info <= i_info;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                r_codes[j]             <= i_press_codes[j];
                r_codes[j + KEY_SLOTS] <= i_release_codes[j];
            end
        end else if (emit) begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_last     <= last;
            r_rejected <= r_info.rejected;
            if (any_event) begin
                r_code    <= r_codes[sel_idx];
                r_mods    <= sel_release ? r_info.prev_mods : r_info.mods;
                r_pressed <= !sel_release;
                r_event   <= 1'b1;
            end else begin
                r_code    <= '0;
                r_mods    <= '0;
                r_pressed <= 1'b0;
                r_event   <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mapped_keycode  = r_code;
    assign o_event_modifiers = r_mods;
    assign o_key_pressed     = r_pressed;
    assign o_has_event       = r_event;
    assign o_rejected        = r_rejected;
    assign o_last_of_report  = r_last;

endmodule

// ===== design/hbkrd_checker.sv =====
// Port-level checker for the boot keyboard report differ, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hbkrd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_mapped_keycode,
    input logic [7:0] o_event_modifiers,
    input logic       o_key_pressed,
    input logic       o_has_event,
    input logic       o_rejected,
    input logic       o_last_of_report
);

    `ASSERT_PROP(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_mapped_keycode) && $stable(o_event_modifiers) && $stable(o_key_pressed) && $stable(o_has_event) && $stable(o_last_of_report), "result word changed while stalled")
    `ASSERT_PROP(a_reject_empty, i_clk, i_rst_n, o_valid && o_rejected |-> o_last_of_report && !o_key_pressed && o_mapped_keycode == 7'd0 && o_event_modifiers == 8'd0, "rejected word is not an empty final word")
    `ASSERT_PROP(a_empty_last, i_clk, i_rst_n, o_valid && !o_has_event |-> o_last_of_report && !o_key_pressed, "empty word is not final")
    `ASSERT_NEVER(a_event_rejected, i_clk, i_rst_n, o_valid && o_has_event && o_rejected, "key event on a rejected report")

endmodule

bind hid_boot_keyboard_report_differ_core hbkrd_checker u_hbkrd_checker (.*);

// ===== tb/tb_hid_boot_keyboard_report_differ_core.sv =====
// Self-checking testbench for hid_boot_keyboard_report_differ_core: directed reports, then
// random report sequences under three idle/stall mixes, each result word checked in order.
// Depends on hbkrd_pkg for key types and report constants; no files or plusargs.
module tb_hid_boot_keyboard_report_differ_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hbkrd_pkg::*;

    localparam int CFG_SETTLE  = 8;
    localparam int TAIL_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 110;

    typedef t_key [0:INPUT_SLOTS-1] t_slots;

    typedef struct packed {
        t_key   mods;
        t_slots keys;
        t_key   len;
    } t_report;

    typedef struct packed {
        t_code code;
        t_key  mods;
        logic  pressed;
        logic  has_event;
        logic  rejected;
        logic  last;
    } t_key_event;

    typedef enum logic [1:0] {OP_REPORT, OP_ENABLE_WRITE} t_row_op;
    typedef enum logic [1:0] {OUT_PREDICT, OUT_REJECT, OUT_QUIET} t_outcome;

    typedef struct packed {
        t_row_op  op;
        logic     cfg_val;
        t_report  rpt;
        t_outcome outcome;
    } t_dir_row;

    localparam t_key_event REJECT_WORD = '{'0, '0, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam t_key_event QUIET_WORD  = '{'0, '0, 1'b0, 1'b0, 1'b0, 1'b1};

    // Usage code to key code, kept independently of the design's table
    localparam t_code USAGE_LUT [ROM_SIZE] = '{
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h0B, 7'h08, 7'h02,
        7'h0E, 7'h03, 7'h05, 7'h04, 7'h22, 7'h26, 7'h28, 7'h25,
        7'h2E, 7'h2D, 7'h1F, 7'h23, 7'h0C, 7'h0F, 7'h01, 7'h11,
        7'h20, 7'h09, 7'h0D, 7'h07, 7'h10, 7'h06, 7'h12, 7'h13,
        7'h14, 7'h15, 7'h17, 7'h16, 7'h1A, 7'h1C, 7'h19, 7'h1D,
        7'h24, 7'h35, 7'h33, 7'h30, 7'h31, 7'h1B, 7'h18, 7'h21,
        7'h1E, 7'h2A, 7'h29, 7'h27, 7'h32, 7'h2B, 7'h2F, 7'h2C,
        7'h39
    };

    localparam t_dir_row DIRECTED [25] = '{
        '{OP_REPORT,       1'b0, '{8'hFF, 48'h04_05_06_07_08_09, 8'd8},   OUT_REJECT},
        '{OP_ENABLE_WRITE, 1'b1, '0,                                     OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h01, 48'h04_05_06_07_08_09, 8'd7},   OUT_REJECT},
        '{OP_REPORT,       1'b0, '{8'h00, 48'h04_05_06_07_08_09, 8'd0},   OUT_REJECT},
        '{OP_REPORT,       1'b0, '{8'h00, 48'h00_00_00_00_00_00, 8'd8},   OUT_QUIET},
        '{OP_REPORT,       1'b0, '{8'h02, 48'h04_05_06_07_08_09, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h80, 48'h09_08_07_06_05_04, 8'd255}, OUT_QUIET},
        '{OP_REPORT,       1'b0, '{8'hFF, 48'h0A_0B_0C_0D_0E_0F, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h00, 48'h01_01_00_00_01_00, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h55, 48'h38_39_FF_80_7F_02, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'hAA, 48'h05_05_05_00_00_00, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h00, 48'h00_00_00_00_00_00, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h7E, 48'h01_01_01_01_01_01, 8'd8},   OUT_QUIET},
        '{OP_ENABLE_WRITE, 1'b0, '0,                                     OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h00, 48'h04_05_06_07_08_09, 8'd8},   OUT_REJECT},
        '{OP_REPORT,       1'b0, '{8'hFF, 48'hFF_FF_FF_FF_FF_FF, 8'd255}, OUT_REJECT},
        '{OP_ENABLE_WRITE, 1'b0, '0,                                     OUT_PREDICT},
        '{OP_ENABLE_WRITE, 1'b1, '0,                                     OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h11, 48'h04_05_06_07_08_09, 8'd8},   OUT_PREDICT},
        '{OP_ENABLE_WRITE, 1'b1, '0,                                     OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h22, 48'h04_05_06_07_08_09, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h00, 48'hFF_FF_FF_FF_FF_FF, 8'd8},   OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'hFF, 48'hAA_55_33_CC_0F_F0, 8'd128}, OUT_PREDICT},
        '{OP_REPORT,       1'b0, '{8'h0F, 48'h00_00_00_00_00_00, 8'd7},   OUT_REJECT},
        '{OP_REPORT,       1'b0, '{8'hF0, 48'h00_2C_00_01_00_00, 8'd9},   OUT_PREDICT}
    };

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_modifier_bits = '0;
    logic [7:0] i_key_slot_0 = '0;
    logic [7:0] i_key_slot_1 = '0;
    logic [7:0] i_key_slot_2 = '0;
    logic [7:0] i_key_slot_3 = '0;
    logic [7:0] i_key_slot_4 = '0;
    logic [7:0] i_key_slot_5 = '0;
    logic [7:0] i_report_length = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [6:0] o_mapped_keycode;
    logic [7:0] o_event_modifiers;
    logic       o_key_pressed;
    logic       o_has_event;
    logic       o_rejected;
    logic       o_last_of_report;

    // Predictor state: stored report and enable
    t_slots prev_keys = '0;
    t_key   prev_mods = '0;
    logic   kbd_enabled = 1'b0;

    t_key_event expected_events[$];
    t_key_event new_words[$];

    t_slots last_keys = '0;
    t_key   last_mods = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int reports_sent = 0;
    int words_checked = 0;
    int events_seen = 0;
    int rejects_seen = 0;
    int quiet_seen = 0;

    hid_boot_keyboard_report_differ_core #(.KEY_SLOTS(INPUT_SLOTS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_modifier_bits  (i_modifier_bits),
        .i_key_slot_0     (i_key_slot_0),
        .i_key_slot_1     (i_key_slot_1),
        .i_key_slot_2     (i_key_slot_2),
        .i_key_slot_3     (i_key_slot_3),
        .i_key_slot_4     (i_key_slot_4),
        .i_key_slot_5     (i_key_slot_5),
        .i_report_length  (i_report_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mapped_keycode (o_mapped_keycode),
        .o_event_modifiers(o_event_modifiers),
        .o_key_pressed    (o_key_pressed),
        .o_has_event      (o_has_event),
        .o_rejected       (o_rejected),
        .o_last_of_report (o_last_of_report)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_code usage_to_code(input t_key usage);
        if (usage < ROM_SIZE) return USAGE_LUT[usage[ROM_IDX_W-1:0]];
        return '0;
    endfunction

    function automatic logic key_listed(input t_slots slots, input t_key usage);
        for (int i = 0; i < INPUT_SLOTS; i++) begin
            if (slots[i] == usage) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Fill new_words with the result words of one accepted report and advance state unless rejected
    function automatic void predict_key_events(input t_report rpt);
        t_key_event held;
        logic       have_held;
        have_held = 1'b0;
        held = '0;
        new_words.delete();
        if (rpt.len < MIN_REPORT_LENGTH || !kbd_enabled) begin
            new_words.push_back(REJECT_WORD);
            return;
        end
        for (int i = 0; i < INPUT_SLOTS; i++) begin
            if (rpt.keys[i] > LAST_NULL_CODE && !key_listed(prev_keys, rpt.keys[i])) begin
                if (have_held) new_words.push_back(held);
                held = '{usage_to_code(rpt.keys[i]), rpt.mods, 1'b1, 1'b1, 1'b0, 1'b0};
                have_held = 1'b1;
            end
        end
        for (int i = 0; i < INPUT_SLOTS; i++) begin
            if (prev_keys[i] > LAST_NULL_CODE && !key_listed(rpt.keys, prev_keys[i])) begin
                if (have_held) new_words.push_back(held);
                held = '{usage_to_code(prev_keys[i]), prev_mods, 1'b0, 1'b1, 1'b0, 1'b0};
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            new_words.push_back(held);
        end else begin
            new_words.push_back(QUIET_WORD);
        end
        prev_keys = rpt.keys;
        prev_mods = rpt.mods;
    endfunction

    function automatic t_key random_usage();
        int sel;
        sel = $urandom_range(19);
        if (sel < 7) return '0;
        if (sel < 15) return t_key'($urandom_range(ROM_SIZE - 1, 2));
        if (sel < 18) return t_key'($urandom_range(255));
        return LAST_NULL_CODE;
    endfunction

    // Mostly small edits of the previous report so keys overlap, now and then a fresh one
    function automatic t_report random_report();
        t_report rpt;
        logic    scramble;
        scramble = ($urandom_range(19) == 0);
        rpt.mods = ($urandom_range(3) == 0) ? last_mods : t_key'($urandom);
        rpt.keys = last_keys;
        for (int i = 0; i < INPUT_SLOTS; i++) begin
            if (scramble || $urandom_range(9) < 3) rpt.keys[i] = random_usage();
        end
        if ($urandom_range(9) == 0) begin
            rpt.len = t_key'($urandom_range(MIN_REPORT_LENGTH - 1));
        end else if ($urandom_range(3) == 0) begin
            rpt.len = t_key'($urandom_range(255, MIN_REPORT_LENGTH));
        end else begin
            rpt.len = t_key'(MIN_REPORT_LENGTH);
        end
        last_keys = rpt.keys;
        last_mods = rpt.mods;
        return rpt;
    endfunction

    // Called just after a rising edge; returns just after a rising edge
    task automatic send_report(input t_report rpt, input t_outcome outcome);
        int gap;
        i_modifier_bits <= rpt.mods;
        i_key_slot_0    <= rpt.keys[0];
        i_key_slot_1    <= rpt.keys[1];
        i_key_slot_2    <= rpt.keys[2];
        i_key_slot_3    <= rpt.keys[3];
        i_key_slot_4    <= rpt.keys[4];
        i_key_slot_5    <= rpt.keys[5];
        i_report_length <= rpt.len;
        i_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_key_events(rpt);
        case (outcome)
            OUT_REJECT: expected_events.push_back(REJECT_WORD);
            OUT_QUIET: expected_events.push_back(QUIET_WORD);
            OUT_PREDICT: foreach (new_words[k]) expected_events.push_back(new_words[k]);
            default: expected_events.push_back(REJECT_WORD);
        endcase
        reports_sent++;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        if (i_valid) i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
    endtask

    task automatic write_enable(input logic value);
        drain_results();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        kbd_enabled = value;
        if (value) begin
            prev_keys = '0;
            prev_mods = '0;
        end
    endtask

    function automatic void field_check(input string field, input int want, input int got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endfunction

    task automatic check_result_word();
        t_key_event got;
        t_key_event want;
        got = '{o_mapped_keycode, o_event_modifiers, o_key_pressed, o_has_event,
                o_rejected, o_last_of_report};
        words_checked++;
        if (expected_events.size() == 0) begin
            fail_count++;
            $display("%0t: result word with nothing expected, expected none, actual 0x%0h",
                     $time, got);
            return;
        end
        want = expected_events.pop_front();
        field_check("mapped_keycode", want.code, got.code);
        field_check("event_modifiers", want.mods, got.mods);
        field_check("key_pressed", want.pressed, got.pressed);
        field_check("has_event", want.has_event, got.has_event);
        field_check("rejected", want.rejected, got.rejected);
        field_check("last_of_report", want.last, got.last);
        if (want.has_event) events_seen++;
        else if (want.rejected) rejects_seen++;
        else quiet_seen++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result_word();
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].op == OP_ENABLE_WRITE) write_enable(DIRECTED[r].cfg_val);
            else send_report(DIRECTED[r].rpt, DIRECTED[r].outcome);
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 56 : 0;
            stall_pct     = (ph == 0) ? 56 : (ph == 1) ? 25 : 0;
            write_enable(1'b1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // drop the keyboard for a stretch, then reattach it
                if (ph == 0 && n == 50) write_enable(1'b0);
                if (ph == 0 && n == 58) write_enable(1'b1);
                // hold off the sender until the block has emptied
                if (ph == 2 && n == 60) drain_results();
                send_report(random_report(), OUT_PREDICT);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d reports and %0d result words under three idle/stall mixes",
                 reports_sent, words_checked);
        $display("  %0d key events, %0d refused reports, %0d reports with no change",
                 events_seen, rejects_seen, quiet_seen);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d result words still expected", expected_events.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
